/* src/fhd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FHd accumulator package
// Shared widths, register indexes, queue word type and the quarter-wave
// sine polynomial constants.
// ----------------------------------------------------------------------------
package fhd_pkg;

  localparam int MaxSamples = 256;
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int CntW       = $clog2(MaxSamples + 1);

  localparam logic [0:0] CfgSampleCount = 1'b0;
  localparam logic [0:0] CfgVoxelCount  = 1'b1;

  localparam logic [22:0] SinA = 23'd6588397;
  localparam logic [22:0] SinB = 23'd2691035;
  localparam logic [22:0] SinC = 23'd296942;

  // One voxel word handed from the front part to the back part.
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [31:0] start_re;
    logic signed [31:0] start_im;
    logic               last;
  } voxel_t;

  // Saturating add of a Q16 term to a 32-bit accumulator.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [36:0] d);
    logic signed [37:0] r;
    r = 38'(a) + 38'(d);
    if (r > 38'sh7FFFFFFF) return 32'sh7FFFFFFF;
    else if (r < -38'sh80000000) return 32'sh80000000;
    else return r[31:0];
  endfunction

endpackage

/* src/mri_fhd_accumulator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FHd accumulator top level
// Each voxel word walks the sample tables, one table sample per cycle
// through an 8-stage phase/sine/product pipe, then a bit-serial square
// root. One voxel at a time; load words go straight to the tables but
// wait while a voxel is queued or being summed.
// Synchronous active-low reset clears control, counter and registers
// (sample_count 256, voxel_count 1024); sample tables are not cleared.
// ----------------------------------------------------------------------------
module mri_fhd_accumulator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [16:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample_index, k_x, k_y, k_z, weight_re, weight_im, pos_x, pos_y, pos_z,
  // start_re, start_im (lowest first)
  input  logic [199:0] in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sum_re, sum_im, magnitude (lowest first)
  output logic [95:0]  out_tdata,
  output logic         out_tlast
);
  import fhd_pkg::*;

  logic [8:0]  sc_r;
  logic [16:0] vc_r;
  logic        tab_we, q_valid, q_pop, back_busy;
  logic [IdxW-1:0] waddr, raddr;
  logic [79:0] wdata, rdata;
  voxel_t      q_word;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= 9'd256; vc_r <= 17'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgSampleCount: sc_r <= cfg_wdata[8:0];
        CfgVoxelCount:  vc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fhd_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .voxel_count(vc_r), .back_busy, .tab_we, .tab_waddr(waddr), .tab_wdata(wdata),
    .q_valid, .q_pop, .q_word
  );

  fhd_ram #(.Width(80), .Depth(MaxSamples)) u_tab (
    .clk, .we(tab_we), .waddr, .wdata, .raddr, .rdata
  );

  fhd_back u_back (
    .clk, .rst_n, .sample_count(sc_r), .q_valid, .q_pop, .q_word,
    .busy(back_busy), .tab_raddr(raddr), .tab_rdata(rdata),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

/* src/fhd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module fhd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/fhd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FHd front part
// Accepts input words, writes load words into the sample tables, and queues
// voxel words with their end-of-volume flag for the back part.
// ----------------------------------------------------------------------------
module fhd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [199:0]          in_tdata,
  input  logic                  in_tuser,
  input  logic [16:0]           voxel_count,
  input  logic                  back_busy,
  output logic                  tab_we,
  output logic [fhd_pkg::IdxW-1:0] tab_waddr,
  output logic [79:0]           tab_wdata,
  output logic                  q_valid,
  input  logic                  q_pop,
  output fhd_pkg::voxel_t       q_word
);
  import fhd_pkg::*;

  localparam int QDepth = 2;

  voxel_t      q_mem_r [QDepth];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [16:0] vcnt_r, vcnt_nxt;
  logic        acc, push, last;
  voxel_t      w;

  // A load waits until no voxel is queued or being summed, so that a voxel
  // always sees the tables as they were when it was accepted.
  assign in_tready = in_tuser ? (cnt_r != 2'(QDepth)) : (cnt_r == 2'd0 && !back_busy);
  assign acc  = in_tvalid && in_tready;
  assign push = acc && in_tuser;

  // Load words go straight to the tables: k_x,k_y,k_z,w_re,w_im.
  assign tab_we    = acc && !in_tuser;
  assign tab_waddr = in_tdata[IdxW-1:0];
  assign tab_wdata = in_tdata[87:8];

  // Volume position counter.
  assign last = (18'(vcnt_r) + 18'd1) >= 18'(voxel_count);
  always_comb begin
    vcnt_nxt = vcnt_r;
    if (push) vcnt_nxt = last ? 17'd0 : vcnt_r + 17'd1;
  end

  always_comb begin
    w.pos_x    = in_tdata[103:88];
    w.pos_y    = in_tdata[119:104];
    w.pos_z    = in_tdata[135:120];
    w.start_re = in_tdata[167:136];
    w.start_im = in_tdata[199:168];
    w.last     = last;
  end

  // Two-entry queue pointers.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
      vcnt_r <= 17'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
      vcnt_r <= vcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= w;
  end

  assign q_valid = cnt_r != 2'd0;
  assign q_word  = q_mem_r[rp_r];

endmodule

/* src/fhd_sine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FHd sine unit
// Pipelined sine of a 24-bit turn phase, signed Q1.15 result, four
// register stages with one multiplier each.
// ----------------------------------------------------------------------------
module fhd_sine (
  input  logic               clk,
  input  logic [23:0]        u,
  output logic signed [15:0] s
);
  import fhd_pkg::*;

  logic [22:0] f;
  logic [22:0] z1_r, z2_r, z3_r;
  logic [22:0] zz1_r, zz2_r;
  logic [22:0] t1_r, t2_r;
  logic        n1_r, n2_r, n3_r, n4_r;
  logic [22:0] s4_r;
  logic [45:0] p1, p2, p3, p4;
  logic [16:0] q;

  assign f  = u[22] ? 23'h400000 - {1'b0, u[21:0]} : {1'b0, u[21:0]};
  assign p1 = f * f;

  always_ff @(posedge clk) begin
    z1_r <= f; zz1_r <= p1[44:22]; n1_r <= u[23];
    z2_r <= z1_r; zz2_r <= zz1_r; n2_r <= n1_r;
    t1_r <= SinB - p2[44:22];
    z3_r <= z2_r; n3_r <= n2_r;
    t2_r <= SinA - p3[44:22];
    s4_r <= p4[44:22]; n4_r <= n3_r;
  end

  assign p2 = zz1_r * SinC;
  assign p3 = zz2_r * t1_r;
  assign p4 = z3_r * t2_r;

  // Round to Q15 and clamp.
  always_comb begin
    q = 17'((24'(s4_r) + 24'd64) >> 7);
    if (q > 17'd32767) q = 17'd32767;
  end
  assign s = n4_r ? -$signed(q[15:0]) : $signed(q[15:0]);

endmodule

/* src/fhd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FHd back part
// Walks the sample tables for one voxel: phase, sine/cosine, complex
// product and saturating accumulation, then a bit-serial square root.
// ----------------------------------------------------------------------------
module fhd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [8:0]               sample_count,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  fhd_pkg::voxel_t          q_word,
  output logic                     busy,
  output logic [fhd_pkg::IdxW-1:0] tab_raddr,
  input  logic [79:0]              tab_rdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [95:0]              out_tdata,
  output logic                     out_tlast
);
  import fhd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_RUN = 5'b00010, S_DRAIN = 5'b00100,
    S_SQRT = 5'b01000, S_OUT = 5'b10000
  } state_t;

  localparam int Lat = 8;

  state_t state_r, state_nxt;
  voxel_t vox_r;
  logic [CntW-1:0] issue_r, issue_nxt, cnt_lim;
  logic [CntW-1:0] done_r, done_nxt;
  logic [Lat-1:0]  vld_r;
  logic signed [31:0] acc_re_r, acc_im_r;
  logic signed [63:0] re_sq, im_sq;
  logic [63:0] rem_r, sq_r;
  logic [31:0] root_r;
  logic [5:0]  it_r;
  logic        last_r;

  assign cnt_lim = (sample_count > 9'(MaxSamples)) ? CntW'(MaxSamples)
                                                   : CntW'(sample_count);
  assign tab_raddr = issue_r[IdxW-1:0];
  assign busy      = state_r != S_IDLE;

  // Stage 1: table data, three products.
  logic signed [15:0] kx, ky, kz, wr, wi;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [15:0] wr1_r, wi1_r, wr2_r, wi2_r;
  logic signed [15:0] wpipe_re [4], wpipe_im [4];
  logic [23:0] ph_r;
  logic signed [15:0] sn, cs;
  logic signed [31:0] m0_r, m1_r, m2_r, m3_r;
  logic signed [32:0] dre, dim;

  assign {wi, wr, kz, ky, kx} = tab_rdata;

  always_ff @(posedge clk) begin
    px_r  <= kx * vox_r.pos_x;
    py_r  <= ky * vox_r.pos_y;
    pz_r  <= kz * vox_r.pos_z;
    wr1_r <= wr; wi1_r <= wi;
    ph_r  <= px_r[23:0] + py_r[23:0] + pz_r[23:0];
    wr2_r <= wr1_r; wi2_r <= wi1_r;
    wpipe_re[0] <= wr2_r; wpipe_im[0] <= wi2_r;
    for (int i = 1; i < 4; i++) begin
      wpipe_re[i] <= wpipe_re[i-1]; wpipe_im[i] <= wpipe_im[i-1];
    end
    m0_r <= wpipe_re[3] * cs; m1_r <= wpipe_im[3] * sn;
    m2_r <= wpipe_im[3] * cs; m3_r <= wpipe_re[3] * sn;
  end

  fhd_sine u_sin (.clk(clk), .u(ph_r), .s(sn));
  fhd_sine u_cos (.clk(clk), .u(ph_r + 24'h400000), .s(cs));

  // Complex terms rounded to Q16.
  assign dre = 33'(m0_r) - 33'(m1_r) + 33'sd4096;
  assign dim = 33'(m2_r) + 33'(m3_r) + 33'sd4096;

  // Squared parts for the magnitude.
  assign re_sq = acc_re_r * acc_re_r;
  assign im_sq = acc_im_r * acc_im_r;

  always_comb begin
    state_nxt = state_r;
    issue_nxt = issue_r;
    done_nxt  = done_r;
    q_pop     = 1'b0;
    unique case (state_r)
      S_IDLE: if (q_valid) begin
        q_pop = 1'b1; state_nxt = S_RUN; issue_nxt = '0; done_nxt = '0;
      end
      S_RUN: begin
        if (issue_r == cnt_lim) state_nxt = S_DRAIN;
        else issue_nxt = issue_r + 1'b1;
      end
      S_DRAIN: if (done_r == cnt_lim && vld_r == '0) state_nxt = S_SQRT;
      S_SQRT: if (it_r == 6'd32) state_nxt = S_OUT;
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (vld_r[Lat-1]) done_nxt = done_r + 1'b1;
  end

  // Issue valid travels with the read: RAM, mult, phase, 4 sine, mult.
  logic issue_v;
  assign issue_v = (state_r == S_RUN) && (issue_r != cnt_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; vld_r <= '0;
    end else begin
      state_r <= state_nxt; vld_r <= {vld_r[Lat-2:0], issue_v};
    end
    issue_r <= issue_nxt;
    done_r  <= done_nxt;
    if (state_r == S_IDLE) begin
      vox_r    <= q_word;
      acc_re_r <= q_word.start_re;
      acc_im_r <= q_word.start_im;
    end else if (vld_r[Lat-1]) begin
      acc_re_r <= sat_add(acc_re_r, 37'(dre >>> 13));
      acc_im_r <= sat_add(acc_im_r, 37'(dim >>> 13));
    end
    // Square root: one result bit per cycle, restoring.
    if (state_r == S_DRAIN) begin
      sq_r   <= re_sq + im_sq;
      rem_r  <= '0;
      root_r <= '0;
      it_r   <= '0;
    end else if (state_r == S_SQRT && it_r != 6'd32) begin
      logic [65:0] r2, trial;
      r2    = {rem_r, sq_r[63:62]};
      trial = {root_r, 2'b01};
      if (r2 >= trial) begin
        rem_r  <= 64'(r2 - trial); root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= r2[63:0]; root_r <= {root_r[30:0], 1'b0};
      end
      sq_r <= {sq_r[61:0], 2'b00};
      it_r <= it_r + 6'd1;
    end
    last_r <= vox_r.last;
  end

  assign out_tvalid = state_r == S_OUT;
  // out_tdata: sum_re, sum_im, magnitude.
  assign out_tdata  = {root_r, acc_im_r, acc_re_r};
  assign out_tlast  = last_r;

endmodule

/* bench/mri_fhd_accumulator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FHd accumulator testbench
// Loads k-space samples and streams voxel words through the accumulator. A
// bit-exact fixed-point FHd sum computed here predicts every voxel result,
// and each result word is checked field by field. Runs cover directed
// extremes, several sample and volume counts, random traffic with idle
// bursts on both sides, and a long output stall.
// ----------------------------------------------------------------------------
module mri_fhd_accumulator_unit_tb;
  import fhd_pkg::*;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeVoxel = 1'b1;
  localparam int   StallLimit = 6000;
  localparam int   DrainCycles = 400;
  localparam int   HoldCycles = 1500;

  typedef struct {
    logic [31:0] sum_re;
    logic [31:0] sum_im;
    logic [31:0] magnitude;
    logic        end_of_volume;
  } voxel_result_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [16:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic         out_tlast;

  // Local copy of the block state.
  logic signed [15:0] kx_tab[MaxSamples];
  logic signed [15:0] ky_tab[MaxSamples];
  logic signed [15:0] kz_tab[MaxSamples];
  logic signed [15:0] wr_tab[MaxSamples];
  logic signed [15:0] wi_tab[MaxSamples];
  bit                 loaded[MaxSamples];
  int                 samples_per_voxel;
  int                 volume_size;
  int                 voxel_index;

  voxel_result_t pending_voxels[$];
  bit  failed;
  bit  src_idle_en;
  bit  snk_idle_en;
  bit  hold_req;
  int  loads_sent;
  int  voxels_sent;
  int  voxels_checked;
  int  flags_seen;
  int  quiet_cycles;

  mri_fhd_accumulator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Quarter-wave sine polynomial, z in Q22, result Q15.
  function automatic longint quarter_sine(input longint z);
    longint z2, t, s, q;
    z2 = (z * z) >> 22;
    t  = longint'(SinB) - ((z2 * longint'(SinC)) >> 22);
    t  = longint'(SinA) - ((z2 * t) >> 22);
    s  = (z * t) >> 22;
    q  = (s + 64) >> 7;
    if (q > 32767) q = 32767;
    return q;
  endfunction

  // Sine of a 24-bit phase in turns, signed Q1.15.
  function automatic longint turn_sine(input longint u);
    longint f, s;
    logic [1:0] quad;
    quad = u[23:22];
    f = u & 64'h3FFFFF;
    if (quad[0]) f = 64'h400000 - f;
    s = quarter_sine(f);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // FHd sum of one voxel over the first stored samples; advances the counter.
  function automatic voxel_result_t fhd_voxel(input logic [199:0] d);
    voxel_result_t r;
    longint px, py, pz, acc_re, acc_im, ph, u, s, c, wr, wi, n;
    longint unsigned are, aim;
    px = longint'($signed(d[103:88]));
    py = longint'($signed(d[119:104]));
    pz = longint'($signed(d[135:120]));
    acc_re = longint'($signed(d[167:136]));
    acc_im = longint'($signed(d[199:168]));
    n = (samples_per_voxel > MaxSamples) ? MaxSamples : samples_per_voxel;
    for (int m = 0; m < n; m++) begin
      ph = longint'(kx_tab[m]) * px + longint'(ky_tab[m]) * py + longint'(kz_tab[m]) * pz;
      u  = ph & 64'hFFFFFF;
      s  = turn_sine(u);
      c  = turn_sine((u + 64'h400000) & 64'hFFFFFF);
      wr = longint'(wr_tab[m]);
      wi = longint'(wi_tab[m]);
      acc_re = sat32(acc_re + ((wr * c - wi * s + 4096) >>> 13));
      acc_im = sat32(acc_im + ((wi * c + wr * s + 4096) >>> 13));
    end
    are = (acc_re < 0) ? -acc_re : acc_re;
    aim = (acc_im < 0) ? -acc_im : acc_im;
    r.sum_re = acc_re[31:0];
    r.sum_im = acc_im[31:0];
    r.magnitude = 32'(floor_sqrt(are * are + aim * aim));
    r.end_of_volume = (voxel_index + 1) >= volume_size;
    voxel_index = r.end_of_volume ? 0 : ((voxel_index + 1) & 17'h1FFFF);
    return r;
  endfunction

  // Field value biased toward the extremes.
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      default: return {$urandom} >>> $urandom_range(0, 12);
    endcase
  endfunction

  // Word layout: sample_index, k, weight, position, start value.
  function automatic logic [199:0] pack_word(input logic [7:0] idx,
      input logic [15:0] kx, ky, kz, wr, wi, px, py, pz,
      input logic [31:0] sre, sim);
    return {sim, sre, pz, py, px, wi, wr, kz, ky, kx, idx};
  endfunction

  function automatic logic [199:0] random_load(input int idx);
    return pack_word(8'(idx), pick16(), pick16(), pick16(), pick16(), pick16(),
                     pick16(), pick16(), pick16(), pick32(), pick32());
  endfunction

  function automatic logic [199:0] random_voxel();
    return pack_word(8'($urandom), pick16(), pick16(), pick16(), pick16(),
                     pick16(), pick16(), pick16(), pick16(), pick32(), pick32());
  endfunction

  function automatic int first_unloaded(input int n);
    int lim;
    lim = (n > MaxSamples) ? MaxSamples : n;
    for (int i = 0; i < lim; i++) if (!loaded[i]) return i;
    return -1;
  endfunction

  // Offers one word and updates the local state once it is taken.
  task automatic send_word(input logic mode, input logic [199:0] d);
    int idx;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    if (mode == ModeLoad) begin
      idx = d[7:0];
      kx_tab[idx] = d[23:8];
      ky_tab[idx] = d[39:24];
      kz_tab[idx] = d[55:40];
      wr_tab[idx] = d[71:56];
      wi_tab[idx] = d[87:72];
      loaded[idx] = 1'b1;
      loads_sent++;
    end else begin
      pending_voxels.push_back(fhd_voxel(d));
      voxels_sent++;
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Register writes happen only once the block has drained.
  task automatic write_reg(input logic [0:0] idx, input int value);
    wait (pending_voxels.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = 17'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CfgSampleCount) samples_per_voxel = value & 9'h1FF;
    else volume_size = value & 17'h1FFFF;
  endtask

  // Voxel word if the needed samples exist, else load the missing one.
  task automatic send_voxel_or_fill();
    int gap;
    gap = first_unloaded(samples_per_voxel);
    if (gap >= 0) send_word(ModeLoad, random_load(gap));
    else send_word(ModeVoxel, random_voxel());
  endtask

  task automatic test_directed();
    write_reg(CfgSampleCount, 4);
    write_reg(CfgVoxelCount, 3);
    send_word(ModeLoad, pack_word(8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, '0, '0, '0, '0, '0));
    send_word(ModeLoad, pack_word(8'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, '0, '0, '0, '0, '0));
    send_word(ModeLoad, pack_word(8'd2, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF,
                                  16'h0000, '0, '0, '0, '0, '0));
    send_word(ModeLoad, pack_word(8'd3, 16'h1000, 16'h0800, 16'hF000, 16'h4000,
                                  16'hC000, '0, '0, '0, '0, '0));
    send_word(ModeLoad, pack_word(8'd255, 16'h1234, 16'h4321, 16'h0F0F, 16'h1111,
                                  16'h2222, '0, '0, '0, '0, '0));
    send_word(ModeVoxel, pack_word('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_word(ModeVoxel, pack_word('0, '0, '0, '0, '0, '0, 16'h7FFF, 16'h7FFF,
                                   16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_word(ModeVoxel, pack_word('0, '0, '0, '0, '0, '0, 16'h8000, 16'h8000,
                                   16'h8000, 32'h80000000, 32'h80000000));
    send_word(ModeVoxel, pack_word('0, '0, '0, '0, '0, '0, 16'h1000, 16'h0000,
                                   16'hF000, 32'h7FFFFFF0, 32'h80000010));
    send_word(ModeVoxel, pack_word('0, '0, '0, '0, '0, '0, 16'h0800, 16'h0400,
                                   16'h0200, 32'h00010000, 32'hFFFF0000));
    send_word(ModeVoxel, pack_word('0, '0, '0, '0, '0, '0, 16'h8000, 16'h7FFF,
                                   16'h0001, 32'h80000000, 32'h7FFFFFFF));
  endtask

  // Zero sample count, a one-voxel volume and a zero voxel count.
  task automatic test_count_corners();
    write_reg(CfgSampleCount, 0);
    write_reg(CfgVoxelCount, 1);
    repeat (4) send_word(ModeVoxel, random_voxel());
    write_reg(CfgVoxelCount, 0);
    write_reg(CfgSampleCount, 1);
    repeat (4) send_word(ModeVoxel, random_voxel());
  endtask

  // Mixed loads and voxels with random sample and volume counts.
  task automatic test_random_traffic(input int n);
    write_reg(CfgSampleCount, $urandom_range(1, 32));
    write_reg(CfgVoxelCount, $urandom_range(1, 9));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_word(ModeLoad, random_load($urandom_range(0, MaxSamples - 1)));
      else
        send_voxel_or_fill();
    end
  endtask

  // Whole table, clamped count and a 65536-voxel volume.
  task automatic test_full_table();
    for (int i = 0; i < MaxSamples; i++) send_word(ModeLoad, random_load(i));
    write_reg(CfgSampleCount, 256);
    write_reg(CfgVoxelCount, 65536);
    repeat (4) send_word(ModeVoxel, random_voxel());
    write_reg(CfgSampleCount, 511);
    repeat (3) send_word(ModeVoxel, random_voxel());
  endtask

  // The output holds off for a long stretch while voxels keep coming.
  task automatic test_output_stall();
    write_reg(CfgSampleCount, 2);
    write_reg(CfgVoxelCount, 5);
    hold_req = 1'b1;
    repeat (30) send_voxel_or_fill();
  endtask

  // Back-to-back traffic without idle cycles on either side.
  task automatic test_full_rate();
    write_reg(CfgSampleCount, 8);
    write_reg(CfgVoxelCount, 4);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    repeat (60) send_voxel_or_fill();
  endtask

  // Result receiver with idle bursts and one long hold.
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 6) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin
    voxel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_voxels.size() == 0) begin
        $error("unexpected result word: tdata %h tlast %b", out_tdata, out_tlast);
        failed = 1'b1;
      end else begin
        want = pending_voxels.pop_front();
        voxels_checked++;
        if (out_tlast) flags_seen++;
        if (out_tdata[31:0] !== want.sum_re) begin
          $error("sum_re: expected %h, actual %h", want.sum_re, out_tdata[31:0]);
          failed = 1'b1;
        end
        if (out_tdata[63:32] !== want.sum_im) begin
          $error("sum_im: expected %h, actual %h", want.sum_im, out_tdata[63:32]);
          failed = 1'b1;
        end
        if (out_tdata[95:64] !== want.magnitude) begin
          $error("magnitude: expected %h, actual %h", want.magnitude,
                 out_tdata[95:64]);
          failed = 1'b1;
        end
        if (out_tlast !== want.end_of_volume) begin
          $error("end_of_volume: expected %b, actual %b", want.end_of_volume,
                 out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    failed = 1'b0;
    hold_req = 1'b0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    samples_per_voxel = 256;
    volume_size = 1024;
    voxel_index = 0;
    for (int i = 0; i < MaxSamples; i++) loaded[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_count_corners();
    repeat (4) test_random_traffic(150);
    test_full_table();
    test_output_stall();
    test_full_rate();

    wait (pending_voxels.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d sample loads and %0d voxels; %0d results checked,",
             loads_sent, voxels_sent, voxels_checked);
    $display("%0d end-of-volume flags, count corners, full table and a long stall.",
             flags_seen);
    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
src/fhd_pkg.sv
src/fhd_ram.sv
src/fhd_front.sv
src/fhd_sine.sv
src/fhd_back.sv
src/mri_fhd_accumulator_unit.sv
bench/mri_fhd_accumulator_unit_tb.sv
